/* sv/rc6_pkg.sv */
// RC6 block cipher package: shared constants, rotate functions and the controller/datapath command type.
// Used by rc6_ctrl, rc6_datapath and rc6_block_cipher.
`default_nettype none
package rc6_pkg;
  localparam logic [31:0] MAGIC_P = 32'hb7e15163;
  localparam logic [31:0] MAGIC_Q = 32'h9e3779b9;

  // configuration register indexes
  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture input block
    logic init_rk;   // write round key at the init index
    logic mix;       // one key mixing step
    logic pre;       // pre-whitening / first decrypt step
    logic rnd;       // one cipher round
    logic post;      // final whitening
    logic dec;       // direction
  } dp_cmd_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} >> n;
    return w[31:0];
  endfunction
endpackage
`default_nettype wire

/* sv/rc6_datapath.sv */
// RC6 datapath: round key memory, key words, block registers and one round unit.
// Depends on rc6_pkg.
`default_nettype none
module rc6_datapath #(
  parameter int ROUNDS    = 20,
  parameter int KEY_BYTES = 16,
  parameter int NKEYS     = 2 * ROUNDS + 4,
  parameter int IW        = $clog2(NKEYS)
) (
  input  wire logic              clk,
  input  wire rc6_pkg::dp_cmd_t  cmd,
  input  wire logic [IW-1:0]     rk_idx,    // round key write index
  input  wire logic [IW-1:0]     rd_idx,    // round key read index for next cycle
  input  wire logic [1:0]        kw_idx,
  input  wire logic              kw_first,  // reset a/b accumulators
  input  wire logic [63:0]       key_low,
  input  wire logic [63:0]       key_high,
  input  wire logic [127:0]      in_block,
  output logic [127:0]           out_block
);
  logic [31:0] rk [NKEYS];
  logic [31:0] kw [4];
  logic [31:0] acc_a, acc_b;
  logic [31:0] ra, rb, rc, rd;
  logic [31:0] rk_rd, rk_rd2;
  logic [31:0] mix_a, mix_b, t, u;
  logic [31:0] rk_init;
  logic [31:0] rk_wdata;
  logic        rk_we;
  logic [127:0] key_bytes;
  logic [IW-1:0] idx2;

  always_comb begin
    key_bytes = {key_high, key_low};
    for (int i = 0; i < 16; i++) begin
      if (i >= KEY_BYTES) key_bytes[i*8 +: 8] = 8'd0;
    end
  end

  // second read port always takes the odd key of the pair
  assign idx2 = {rd_idx[IW-1:1], 1'b1};
  assign rk_init = rc6_pkg::MAGIC_P + rc6_pkg::MAGIC_Q * 32'(rk_idx);
  assign rk_we = cmd.init_rk || cmd.mix;
  assign rk_wdata = cmd.init_rk ? rk_init : mix_a;

  assign mix_a = rc6_pkg::rotl(rk_rd + acc_a + acc_b, 5'd3);
  assign mix_b = rc6_pkg::rotl(kw[kw_idx] + mix_a + acc_b, 5'(mix_a + acc_b));

  // round function on current block
  assign t = rc6_pkg::rotl(rb * {rb[30:0], 1'b1}, 5'd5);
  assign u = rc6_pkg::rotl(rd * {rd[30:0], 1'b1}, 5'd5);

  // in decrypt, register holds the rotated form {d,a,b,c} already
  logic [31:0] ua, uc, ta, tc, da, dc;
  assign ua = rc6_pkg::rotl(ra ^ t, u[4:0]) + rk_rd;
  assign uc = rc6_pkg::rotl(rc ^ u, t[4:0]) + rk_rd2;
  assign dc = rc6_pkg::rotr(rc - rk_rd2, t[4:0]) ^ u;
  assign da = rc6_pkg::rotr(ra - rk_rd, u[4:0]) ^ t;
  assign ta = ua; assign tc = uc;

  // round key memory: registered reads, pass write data through on a matching address
  always_ff @(posedge clk) begin
    if (rk_we) rk[rk_idx] <= rk_wdata;
    rk_rd  <= (rk_we && rk_idx == rd_idx) ? rk_wdata : rk[rd_idx];
    rk_rd2 <= (rk_we && rk_idx == idx2) ? rk_wdata : rk[idx2];
  end

  always_ff @(posedge clk) begin
    if (cmd.init_rk) begin
      for (int i = 0; i < 4; i++) kw[i] <= key_bytes[i*32 +: 32];
      acc_a <= '0;
      acc_b <= '0;
    end else if (cmd.mix) begin
      kw[kw_idx] <= mix_b;
      acc_a <= kw_first ? 32'd0 : mix_a;
      acc_b <= kw_first ? 32'd0 : mix_b;
    end
    if (cmd.load) begin
      {rd, rc, rb, ra} <= in_block;
    end else if (cmd.pre) begin
      if (!cmd.dec) begin
        rb <= rb + rk_rd;
        rd <= rd + rk_rd2;
      end else begin
        // subtract last keys, rotate into round order
        ra <= rd; rb <= ra - rk_rd; rc <= rb; rd <= rc - rk_rd2;
      end
    end else if (cmd.rnd) begin
      if (!cmd.dec) begin
        ra <= rb; rb <= tc; rc <= rd; rd <= ta;
      end else begin
        // undo round then rotate for next
        ra <= rd; rb <= da; rc <= rb; rd <= dc;
      end
    end else if (cmd.post) begin
      if (!cmd.dec) begin
        ra <= ra + rk_rd;
        rc <= rc + rk_rd2;
      end else begin
        // undo the extra rotation, remove whitening
        ra <= rb; rb <= rc - rk_rd; rc <= rd; rd <= ra - rk_rd2;
      end
    end
  end

  assign out_block = {rd, rc, rb, ra};
endmodule
`default_nettype wire

/* sv/rc6_ctrl.sv */
// RC6 controller: key schedule sequencing and round sequencing.
// Depends on rc6_pkg.
`default_nettype none
module rc6_ctrl #(
  parameter int ROUNDS    = 20,
  parameter int KEY_BYTES = 16,
  parameter int NKEYS     = 2 * ROUNDS + 4,
  parameter int IW        = $clog2(NKEYS)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             key_write,
  input  wire logic             in_valid,
  input  wire logic             in_cmd,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rc6_pkg::dp_cmd_t      cmd,
  output logic [IW-1:0]         rk_idx,
  output logic [IW-1:0]         rd_idx,
  output logic [1:0]            kw_idx,
  output logic                  kw_first
);
  localparam int NWORDS = (KEY_BYTES + 3) / 4;
  localparam int MIXN   = 3 * NKEYS;
  localparam int MW     = $clog2(MIXN + 1);
  localparam int RW     = $clog2(ROUNDS + 2);

  localparam logic [2:0] S_IDLE = 3'd0, S_INIT = 3'd1, S_MIX = 3'd2,
                         S_PRE = 3'd3, S_RND = 3'd4, S_POST = 3'd5, S_OUT = 3'd6;

  logic [2:0] state;
  logic       ready_sched, dec;
  logic [MW-1:0] mcnt;
  logic [IW-1:0] ki;
  logic [IW-1:0] ki_step;
  logic [1:0]    wi;
  logic [RW-1:0] rnd;
  logic [RW-1:0] rnd_step;
  logic          rnd_last;

  assign in_ready  = (state == S_IDLE) && !key_write;
  assign out_valid = (state == S_OUT);
  assign kw_idx    = wi;
  assign kw_first  = 1'b0;
  assign rk_idx    = ki;
  assign ki_step   = (ki == IW'(NKEYS - 1)) ? '0 : ki + IW'(1);
  assign rnd_step  = dec ? rnd - RW'(1) : rnd + RW'(1);
  assign rnd_last  = dec ? (rnd == RW'(1)) : (rnd == RW'(ROUNDS));

  // rd_idx addresses the keys that the next state consumes
  always_comb begin
    cmd = '0;
    cmd.dec = dec;
    rd_idx = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid && in_ready;
        rd_idx = in_cmd ? IW'(2 * ROUNDS + 2) : '0;
      end
      S_INIT: cmd.init_rk = 1'b1;
      S_MIX: begin
        cmd.mix = 1'b1;
        if (mcnt == MW'(MIXN - 1)) rd_idx = dec ? IW'(2 * ROUNDS + 2) : '0;
        else rd_idx = ki_step;
      end
      S_PRE: begin
        cmd.pre = 1'b1;
        rd_idx = dec ? IW'(2 * ROUNDS) : IW'(2);
      end
      S_RND: begin
        cmd.rnd = 1'b1;
        if (rnd_last) rd_idx = dec ? '0 : IW'(2 * ROUNDS + 2);
        else rd_idx = IW'({rnd_step, 1'b0});
      end
      S_POST: cmd.post = 1'b1;
      S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; ready_sched <= 1'b0; dec <= 1'b0;
      mcnt <= '0; ki <= '0; wi <= '0; rnd <= '0;
    end else begin
      if (key_write) ready_sched <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          dec <= in_cmd;
          ki <= '0; wi <= '0; mcnt <= '0;
          state <= ready_sched ? S_PRE : S_INIT;
        end
        S_INIT: begin
          if (ki == IW'(NKEYS - 1)) begin
            ki <= '0;
            state <= S_MIX;
          end else ki <= ki + IW'(1);
        end
        S_MIX: begin
          ki <= ki_step;
          wi <= (wi == 2'(NWORDS - 1)) ? '0 : wi + 2'd1;
          if (mcnt == MW'(MIXN - 1)) begin
            ready_sched <= 1'b1;
            state <= S_PRE;
          end
          mcnt <= mcnt + MW'(1);
        end
        S_PRE: begin
          rnd <= dec ? RW'(ROUNDS) : RW'(1);
          state <= S_RND;
        end
        S_RND: begin
          if (rnd_last) state <= S_POST;
          else rnd <= rnd_step;
        end
        S_POST: state <= S_OUT;
        S_OUT:  if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* sv/rc6_block_cipher.sv */
// RC6-32 block cipher top level: stream ports, key registers, controller and datapath.
// Depends on rc6_pkg, rc6_ctrl, rc6_datapath.
// After acceptance a block gets a whitening step, the rounds (one per cycle through
// the single round unit) and a final whitening step, then is valid on the output.
// The result holds until taken; the input reopens only when the controller is back
// in idle after hand-off, so no new block is accepted before the last is taken.
// After reset or a key write the first block also runs the key schedule: it seeds
// the 2*ROUNDS+4 round keys, then runs 3*(2*ROUNDS+4) mixing steps, one per cycle.
`default_nettype none
module rc6_block_cipher #(
  parameter int ROUNDS    = 20,
  parameter int KEY_BYTES = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [63:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,  // in_word_a, in_word_b, in_word_c, in_word_d
  input  wire logic         s_tuser,  // command
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata   // out_word_a, out_word_b, out_word_c, out_word_d
);
  localparam int NKEYS = 2 * ROUNDS + 4;
  localparam int IW    = $clog2(NKEYS);

  logic [63:0] key_low, key_high;
  rc6_pkg::dp_cmd_t cmd;
  logic [IW-1:0] rk_idx;
  logic [IW-1:0] rd_idx;
  logic [1:0] kw_idx;
  logic kw_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low <= '0; key_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rc6_pkg::REG_KEY_LOW:  key_low <= cfg_data;
        rc6_pkg::REG_KEY_HIGH: key_high <= cfg_data;
        default: ;
      endcase
    end
  end

  rc6_ctrl #(.ROUNDS(ROUNDS), .KEY_BYTES(KEY_BYTES), .NKEYS(NKEYS), .IW(IW)) u_ctrl (
    .clk, .rst, .key_write(cfg_we), .in_valid(s_tvalid), .in_cmd(s_tuser),
    .in_ready(s_tready), .out_valid(m_tvalid), .out_ready(m_tready),
    .cmd, .rk_idx, .rd_idx, .kw_idx, .kw_first
  );

  rc6_datapath #(.ROUNDS(ROUNDS), .KEY_BYTES(KEY_BYTES), .NKEYS(NKEYS), .IW(IW)) u_dp (
    .clk, .cmd, .rk_idx, .rd_idx, .kw_idx, .kw_first, .key_low, .key_high,
    .in_block(s_tdata), .out_block(m_tdata)
  );
endmodule
`default_nettype wire

/* bench/rc6_block_cipher_tb.sv */
// Testbench for rc6_block_cipher: streams blocks through the cipher and checks each
// result against an RC6-32/20/16 predictor kept in the bench. Depends on the RTL and rc6_pkg.
`timescale 1ns / 100ps
module rc6_block_cipher_tb;
  localparam int ROUNDS = 20;
  localparam int NKEYS = 2 * ROUNDS + 4;
  localparam logic [31:0] KEY_P = 32'hb7e15163;
  localparam logic [31:0] KEY_Q = 32'h9e3779b9;
  localparam int STALL_LIMIT = 20000;

  typedef enum logic { CMD_ENCRYPT = 1'b0, CMD_DECRYPT = 1'b1 } cipher_cmd_e;

  typedef struct packed {
    logic [31:0] d;
    logic [31:0] c;
    logic [31:0] b;
    logic [31:0] a;
  } block_t;

  typedef struct {
    cipher_cmd_e cmd;
    block_t blk;
  } cipher_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [63:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [127:0] s_tdata = '0;  // in_word_a, in_word_b, in_word_c, in_word_d
  logic s_tuser = 1'b0;        // command
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [127:0] m_tdata;  // out_word_a, out_word_b, out_word_c, out_word_d

  rc6_block_cipher uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [63:0] key_lo_q = '0, key_hi_q = '0;
  logic [31:0] sched[NKEYS];

  cipher_req_t pending_blocks[$];
  block_t expected_blocks[$];
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit recv_hold = 1'b0;
  int errors = 0;
  int quiet_cycles = 0;

  function automatic logic [31:0] rol32(logic [31:0] x, logic [31:0] n);
    logic [63:0] w;
    w = {x, x} << n[4:0];
    return w[63:32];
  endfunction

  function automatic logic [31:0] ror32(logic [31:0] x, logic [31:0] n);
    logic [63:0] w;
    w = {x, x} >> n[4:0];
    return w[31:0];
  endfunction

  function automatic logic [31:0] quad_mix(logic [31:0] x);
    return rol32(x * (2 * x + 1), 5);
  endfunction

  // rebuild the round keys from the current key registers
  task automatic build_schedule();
    logic [31:0] lw[4];
    logic [31:0] a, b;
    int i, j;
    for (int n = 0; n < 4; n++) lw[n] = '0;
    for (int n = 0; n < 16; n++)
      lw[n / 4] |= 32'((n < 8 ? key_lo_q >> (8 * n) : key_hi_q >> (8 * (n - 8))) & 8'hff)
                   << (8 * (n % 4));
    sched[0] = KEY_P;
    for (int n = 1; n < NKEYS; n++) sched[n] = sched[n - 1] + KEY_Q;
    a = '0; b = '0; i = 0; j = 0;
    for (int k = 0; k < 3 * NKEYS; k++) begin
      sched[i] = rol32(sched[i] + a + b, 3);
      a = sched[i];
      lw[j] = rol32(lw[j] + a + b, a + b);
      b = lw[j];
      i = (i + 1) % NKEYS;
      j = (j + 1) % 4;
    end
  endtask

  function automatic block_t cipher_block(cipher_req_t r);
    logic [31:0] a, b, c, d, t, u, x;
    a = r.blk.a; b = r.blk.b; c = r.blk.c; d = r.blk.d;
    if (r.cmd == CMD_ENCRYPT) begin
      b += sched[0];
      d += sched[1];
      for (int i = 1; i <= ROUNDS; i++) begin
        t = quad_mix(b);
        u = quad_mix(d);
        a = rol32(a ^ t, u) + sched[2 * i];
        c = rol32(c ^ u, t) + sched[2 * i + 1];
        x = a; a = b; b = c; c = d; d = x;
      end
      a += sched[2 * ROUNDS + 2];
      c += sched[2 * ROUNDS + 3];
    end else begin
      c -= sched[2 * ROUNDS + 3];
      a -= sched[2 * ROUNDS + 2];
      for (int i = ROUNDS; i > 0; i--) begin
        x = d; d = c; c = b; b = a; a = x;
        u = quad_mix(d);
        t = quad_mix(b);
        c = ror32(c - sched[2 * i + 1], t) ^ u;
        a = ror32(a - sched[2 * i], u) ^ t;
      end
      d -= sched[1];
      b -= sched[0];
    end
    return '{a: a, b: b, c: c, d: d};
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_blocks.push_back(cipher_block(pending_blocks.pop_front()));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_blocks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_blocks[0].blk;
          s_tuser <= pending_blocks[0].cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        block_t got, want;
        got = m_tdata;
        if (expected_blocks.size() == 0) begin
          $error("unexpected output word %h", m_tdata);
          errors++;
        end else begin
          want = expected_blocks.pop_front();
          if (got.a !== want.a) begin
            $error("out_word_a expected %h got %h", want.a, got.a); errors++;
          end
          if (got.b !== want.b) begin
            $error("out_word_b expected %h got %h", want.b, got.b); errors++;
          end
          if (got.c !== want.c) begin
            $error("out_word_c expected %h got %h", want.c, got.c); errors++;
          end
          if (got.d !== want.d) begin
            $error("out_word_d expected %h got %h", want.d, got.d); errors++;
          end
        end
      end
      m_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
      quiet_cycles <= ((s_tvalid && s_tready) || (m_tvalid && m_tready)) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic cipher_req_t rand_block();
    cipher_req_t r;
    r.cmd = cipher_cmd_e'($urandom_range(1));
    r.blk = {$urandom, $urandom, $urandom, $urandom};
    return r;
  endfunction

  function automatic cipher_req_t make_block(cipher_cmd_e cmd, logic [127:0] v);
    cipher_req_t r;
    r.cmd = cmd;
    r.blk = v;
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_blocks.size() != 0 || s_tvalid || expected_blocks.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // only while idle: the next block reruns the schedule on both sides
  task automatic write_key(logic idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rc6_pkg::REG_KEY_LOW) key_lo_q = val;
    else key_hi_q = val;
    build_schedule();
  endtask

  task automatic run_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int k = 0; k < n; k++) pending_blocks.push_back(rand_block());
    wait_drained();
  endtask

  initial begin
    build_schedule();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: zero key, extremes of both commands
    pending_blocks.push_back(make_block(CMD_ENCRYPT, '0));
    pending_blocks.push_back(make_block(CMD_DECRYPT, '0));
    pending_blocks.push_back(make_block(CMD_ENCRYPT, '1));
    pending_blocks.push_back(make_block(CMD_DECRYPT, '1));
    pending_blocks.push_back(make_block(CMD_ENCRYPT, {4{32'h8000_0001}}));
    pending_blocks.push_back(make_block(CMD_DECRYPT, {4{32'h7fff_fffe}}));
    wait_drained();
    write_key(rc6_pkg::REG_KEY_LOW, '1);
    write_key(rc6_pkg::REG_KEY_HIGH, '1);
    for (int k = 0; k < 4; k++) pending_blocks.push_back(rand_block());
    wait_drained();
    write_key(rc6_pkg::REG_KEY_LOW, 64'h0706050403020100);
    write_key(rc6_pkg::REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
    pending_blocks.push_back(make_block(CMD_ENCRYPT, '0));
    pending_blocks.push_back(make_block(CMD_DECRYPT, 128'h1));
    wait_drained();
    // single register write only
    write_key(rc6_pkg::REG_KEY_HIGH, '0);
    run_phase(6, 0, 0);

    run_phase(150, 0, 0);
    write_key(rc6_pkg::REG_KEY_LOW, {$urandom, $urandom});
    write_key(rc6_pkg::REG_KEY_HIGH, {$urandom, $urandom});
    run_phase(150, 47, 0);
    write_key(rc6_pkg::REG_KEY_LOW, {$urandom, $urandom});
    run_phase(150, 0, 47);
    write_key(rc6_pkg::REG_KEY_HIGH, {$urandom, $urandom});
    run_phase(150, 6, 6);

    // long receiver hold while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 6;
    recv_hold = 1'b1;
    for (int k = 0; k < 80; k++) pending_blocks.push_back(rand_block());
    repeat (400) @(posedge clk);
    recv_hold = 1'b0;
    wait_drained();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
